// ===== design/swlp_pkg.sv =====
`default_nettype none
package swlp_pkg;

    localparam int LINE_CAPACITY_DEF = 32;

    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_G       = 8'h67;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_ZERO    = 8'h30;

    localparam int SIGN_POS   = 0;
    localparam int DIGIT_LAST = 9;
    localparam int SUFFIX_G   = 10;
    localparam int SUFFIX_SP1 = 11;
    localparam int SUFFIX_SP2 = 12;

    typedef struct packed {
        logic               line_ok;
        logic signed [31:0] mass_value;
    } t_result;

    function automatic logic [31:0] fold_digit(input logic [31:0] total,
                                               input logic [7:0]  b);
        logic [31:0] times_ten;
        times_ten  = {total[28:0], 3'b000} + {total[30:0], 1'b0};
        fold_digit = times_ten + {24'd0, b} - {24'd0, CH_ZERO};
    endfunction

endpackage
`default_nettype wire

// ===== design/swlp_in_stage.sv =====
`default_nettype none
module swlp_in_stage (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_move,
    output logic            o_stall,
    output logic            o_valid,
    output logic [7:0]      o_byte
);
    logic       r_valid;
    logic [7:0] r_byte;
    logic       advance;

    assign advance = !r_valid || i_move;
    assign o_stall = !advance;
    assign o_valid = r_valid;
    assign o_byte  = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (advance) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && i_valid) begin
            r_byte <= i_byte;
        end
    end
endmodule
`default_nettype wire

// ===== design/swlp_line_parse.sv =====
`default_nettype none
module swlp_line_parse #(
    parameter int LINE_CAPACITY = swlp_pkg::LINE_CAPACITY_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_fire,
    input  wire logic [7:0] i_byte,
    output logic            o_newline,
    output swlp_pkg::t_result o_result
);
    import swlp_pkg::*;

    localparam int LW = $clog2(LINE_CAPACITY);

    logic [LW-1:0] r_len,    n_len;
    logic [7:0]    r_sign,   n_sign;
    logic [31:0]   r_total,  n_total;
    logic [2:0]    r_suffix, n_suffix;
    logic          ok;

    assign o_newline = (i_byte == CH_NEWLINE);

    always_comb begin
        ok = ((r_sign == CH_MINUS) || (r_sign == CH_PLUS)) && (r_suffix == 3'b111);
        o_result.line_ok    = ok;
        o_result.mass_value = 32'sd0;
        if (ok) begin
            o_result.mass_value = (r_sign == CH_MINUS) ? $signed(32'd0 - r_total)
                                                       : $signed(r_total);
        end
    end

    always_comb begin
        n_len    = r_len;
        n_sign   = r_sign;
        n_total  = r_total;
        n_suffix = r_suffix;
        if (o_newline || (r_len >= LW'(LINE_CAPACITY - 1))) begin
            n_len    = '0;
            n_sign   = '0;
            n_total  = '0;
            n_suffix = '0;
        end else begin
            n_len = r_len + LW'(1);
            if (r_len == LW'(SIGN_POS)) begin
                n_sign = i_byte;
            end else if (r_len <= LW'(DIGIT_LAST)) begin
                if ((i_byte != CH_DOT) && (i_byte != CH_SPACE)) begin
                    n_total = fold_digit(r_total, i_byte);
                end
            end else if (r_len == LW'(SUFFIX_G)) begin
                n_suffix[0] = r_suffix[0] | (i_byte == CH_G);
            end else if (r_len == LW'(SUFFIX_SP1)) begin
                n_suffix[1] = r_suffix[1] | (i_byte == CH_SPACE);
            end else if (r_len == LW'(SUFFIX_SP2)) begin
                n_suffix[2] = r_suffix[2] | (i_byte == CH_SPACE);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= '0;
            r_sign   <= '0;
            r_total  <= '0;
            r_suffix <= '0;
        end else if (i_fire) begin
            r_len    <= n_len;
            r_sign   <= n_sign;
            r_total  <= n_total;
            r_suffix <= n_suffix;
        end
    end
endmodule
`default_nettype wire

// ===== design/swlp_out_stage.sv =====
`default_nettype none
module swlp_out_stage (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire swlp_pkg::t_result i_result,
    input  wire logic              i_stall,
    output logic                   o_ready,
    output logic                   o_valid,
    output swlp_pkg::t_result      o_result
);
    logic              r_valid;
    swlp_pkg::t_result r_result;

    assign o_ready  = !r_valid || !i_stall;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end
endmodule
`default_nettype wire

// ===== design/scale_weight_line_parser.sv =====
// Scale weight line parser.
// Input channel: one serial byte per transfer on i_rx_byte, with i_valid and
// o_stall. Output channel: one result per newline on o_line_ok and
// o_mass_value, with o_valid and i_stall. Other bytes give no result.
// A byte is taken into an input register, folded into the line state by
// the single-cycle parse logic, and a newline's result is held in an output
// register. Throughput is one byte per cycle while o_stall is low.
// While the receiver stalls a waiting result, the block still accepts
// bytes; only a second newline waits in the input register, and o_stall
// rises once that register is blocked.
// Synchronous reset clears the line state and both registers; no result is
// pending after reset.
`default_nettype none
module scale_weight_line_parser #(
    parameter int LINE_CAPACITY = swlp_pkg::LINE_CAPACITY_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [7:0]         i_rx_byte,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic                    o_line_ok,
    output logic signed [31:0]      o_mass_value
);
    import swlp_pkg::*;

    logic       s1_valid;
    logic [7:0] s1_byte;
    logic       s1_newline;
    logic       s1_move;
    logic       s1_fire;
    logic       out_ready;
    t_result    parse_result;
    t_result    out_result;

    assign s1_move = !s1_newline || out_ready;
    assign s1_fire = s1_valid && s1_move;

    swlp_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_byte  (i_rx_byte),
        .i_move  (s1_move),
        .o_stall (o_stall),
        .o_valid (s1_valid),
        .o_byte  (s1_byte)
    );

    swlp_line_parse #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_parse (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (s1_fire),
        .i_byte    (s1_byte),
        .o_newline (s1_newline),
        .o_result  (parse_result)
    );

    swlp_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (s1_fire && s1_newline),
        .i_result (parse_result),
        .i_stall  (i_stall),
        .o_ready  (out_ready),
        .o_valid  (o_valid),
        .o_result (out_result)
    );

    assign o_line_ok    = out_result.line_ok;
    assign o_mass_value = out_result.mass_value;
endmodule
`default_nettype wire

// ===== design/swlp_checker.sv =====
`default_nettype none
module swlp_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_valid,
    input wire logic               o_stall,
    input wire logic [7:0]         i_rx_byte,
    input wire logic               o_valid,
    input wire logic               i_stall,
    input wire logic               o_line_ok,
    input wire logic signed [31:0] o_mass_value
);
    import swlp_pkg::*;

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result pending after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_line_ok) && $stable(o_mass_value))
        else $error("stalled result changed");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_line_ok |-> o_mass_value == 32'sd0)
        else $error("parse error with nonzero value");

    a_newline_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (i_rx_byte == CH_NEWLINE) && !o_valid |=> ##1 o_valid)
        else $error("newline transfer gave no result");
endmodule

bind scale_weight_line_parser swlp_checker u_swlp_checker (.*);
`default_nettype wire
